>>> hdl/mbre_pkg.sv
// Shared types and constants for the monochrome bitmap to RGB565 expander.
// No dependencies; imported by every module of the block.
package mbre_pkg;

    // Largest bitmap the counters cover
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;

    // Field widths
    localparam int BYTE_W      = 8;
    localparam int COLOR_W     = 16;
    localparam int PAL_IDX_W   = 2;
    localparam int PAL_ENTRIES = 4;
    localparam int SIZE_W      = 10;
    localparam int PIX_IDX_W   = 3;
    localparam int BYTE_CNT_W  = $clog2(MAX_WIDTH / 8);
    localparam int ROW_CNT_W   = $clog2(MAX_HEIGHT);

    // APB register map
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;
    localparam int APB_ADDR_W = REG_IDX_W + 2;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PALETTE_0  = 3'd0,
        REG_PALETTE_1  = 3'd1,
        REG_PALETTE_2  = 3'd2,
        REG_PALETTE_3  = 3'd3,
        REG_FG_INDEX   = 3'd4,
        REG_BG_INDEX   = 3'd5,
        REG_ROW_PIXELS = 3'd6,
        REG_IMG_ROWS   = 3'd7
    } mbre_reg_t;

    // Register file contents seen by the datapath
    typedef struct packed {
        logic [PAL_ENTRIES-1:0][COLOR_W-1:0] palette;
        logic [PAL_IDX_W-1:0]                fg_index;
        logic [PAL_IDX_W-1:0]                bg_index;
        logic [SIZE_W-1:0]                   pixels_per_row;
        logic [SIZE_W-1:0]                   rows_per_image;
    } mbre_cfg_t;

    // One bitmap byte with its position already resolved
    typedef struct packed {
        logic [BYTE_W-1:0]    data;
        logic [PIX_IDX_W-1:0] last_idx;   // index of the last pixel to emit
        logic                 last_byte;
        logic                 last_row;
    } mbre_item_t;

endpackage

>>> hdl/mbre_cfg_regs.sv
// APB register file for the expander: palette, color indexes and bitmap size.
// Depends on mbre_pkg.
module mbre_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mbre_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mbre_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mbre_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output mbre_pkg::mbre_cfg_t               cfg
);
    import mbre_pkg::*;

    mbre_cfg_t cfg_reg;
    mbre_cfg_t cfg_next;
    mbre_reg_t reg_sel;
    logic      wr_en;

    assign pready  = 1'b1;
    assign reg_sel = mbre_reg_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_sel)
                REG_PALETTE_0:  cfg_next.palette[0]     = pwdata[COLOR_W-1:0];
                REG_PALETTE_1:  cfg_next.palette[1]     = pwdata[COLOR_W-1:0];
                REG_PALETTE_2:  cfg_next.palette[2]     = pwdata[COLOR_W-1:0];
                REG_PALETTE_3:  cfg_next.palette[3]     = pwdata[COLOR_W-1:0];
                REG_FG_INDEX:   cfg_next.fg_index       = pwdata[PAL_IDX_W-1:0];
                REG_BG_INDEX:   cfg_next.bg_index       = pwdata[PAL_IDX_W-1:0];
                REG_ROW_PIXELS: cfg_next.pixels_per_row = pwdata[SIZE_W-1:0];
                REG_IMG_ROWS:   cfg_next.rows_per_image = pwdata[SIZE_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.palette        <= '0;
            cfg_reg.fg_index       <= PAL_IDX_W'(1);
            cfg_reg.bg_index       <= '0;
            cfg_reg.pixels_per_row <= SIZE_W'(8);
            cfg_reg.rows_per_image <= SIZE_W'(8);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_sel)
            REG_PALETTE_0:  prdata = APB_DATA_W'(cfg_reg.palette[0]);
            REG_PALETTE_1:  prdata = APB_DATA_W'(cfg_reg.palette[1]);
            REG_PALETTE_2:  prdata = APB_DATA_W'(cfg_reg.palette[2]);
            REG_PALETTE_3:  prdata = APB_DATA_W'(cfg_reg.palette[3]);
            REG_FG_INDEX:   prdata = APB_DATA_W'(cfg_reg.fg_index);
            REG_BG_INDEX:   prdata = APB_DATA_W'(cfg_reg.bg_index);
            REG_ROW_PIXELS: prdata = APB_DATA_W'(cfg_reg.pixels_per_row);
            REG_IMG_ROWS:   prdata = APB_DATA_W'(cfg_reg.rows_per_image);
            default:        prdata = '0;
        endcase
    end

endmodule

>>> hdl/mbre_byte_front.sv
// Input stage: accepts bitmap bytes, tracks byte/row position, holds one byte.
// Depends on mbre_pkg.
module mbre_byte_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mbre_pkg::mbre_cfg_t           cfg,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [mbre_pkg::BYTE_W-1:0]   s_bitmap_byte,
    output logic                          item_valid,
    input  logic                          item_ready,
    output mbre_pkg::mbre_item_t          item
);
    import mbre_pkg::*;

    logic [BYTE_CNT_W-1:0] byte_in_row_reg, byte_in_row_next;
    logic [ROW_CNT_W-1:0]  row_count_reg, row_count_next;
    logic                  hold_valid_reg, hold_valid_next;
    mbre_item_t            hold_reg, hold_next;

    logic [SIZE_W-1:0] width_eff;
    logic [SIZE_W-1:0] height_eff;
    logic [SIZE_W-1:0] width_m1;
    logic [SIZE_W:0]   row_bytes;
    logic              last_byte;
    logic              last_row;
    logic              accept;
    mbre_item_t        new_item;

    // Clamp the programmed size into the supported range
    always_comb begin
        if (cfg.pixels_per_row == '0) begin
            width_eff = SIZE_W'(1);
        end else if (cfg.pixels_per_row > SIZE_W'(MAX_WIDTH)) begin
            width_eff = SIZE_W'(MAX_WIDTH);
        end else begin
            width_eff = cfg.pixels_per_row;
        end
        if (cfg.rows_per_image == '0) begin
            height_eff = SIZE_W'(1);
        end else if (cfg.rows_per_image > SIZE_W'(MAX_HEIGHT)) begin
            height_eff = SIZE_W'(MAX_HEIGHT);
        end else begin
            height_eff = cfg.rows_per_image;
        end
    end

    // Position of this byte within the image
    assign width_m1      = width_eff - SIZE_W'(1);
    assign row_bytes     = ({1'b0, width_eff} + (SIZE_W+1)'(7)) >> 3;
    assign last_byte     = ((SIZE_W+1)'(byte_in_row_reg) + (SIZE_W+1)'(1)) >= row_bytes;
    assign last_row      = ((SIZE_W+1)'(row_count_reg) + (SIZE_W+1)'(1))
                           >= {1'b0, height_eff};

    always_comb begin
        new_item.data      = s_bitmap_byte;
        new_item.last_idx  = last_byte ? width_m1[PIX_IDX_W-1:0] : '1;
        new_item.last_byte = last_byte;
        new_item.last_row  = last_row;
    end

    assign s_ready    = !hold_valid_reg || item_ready;
    assign accept     = s_valid && s_ready;
    assign item_valid = hold_valid_reg;
    assign item       = hold_reg;

    // Counters and holding register
    always_comb begin
        byte_in_row_next = byte_in_row_reg;
        row_count_next   = row_count_reg;
        hold_valid_next  = hold_valid_reg;
        hold_next        = hold_reg;
        if (item_valid && item_ready) begin
            hold_valid_next = 1'b0;
        end
        if (accept) begin
            hold_valid_next = 1'b1;
            hold_next       = new_item;
            if (last_byte) begin
                byte_in_row_next = '0;
                row_count_next   = last_row ? '0 : row_count_reg + ROW_CNT_W'(1);
            end else begin
                byte_in_row_next = byte_in_row_reg + BYTE_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_in_row_reg <= '0;
            row_count_reg   <= '0;
            hold_valid_reg  <= 1'b0;
        end else begin
            byte_in_row_reg <= byte_in_row_next;
            row_count_reg   <= row_count_next;
            hold_valid_reg  <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg <= hold_next;
    end

    // A held byte is never overwritten before the serializer takes it
    a_hold_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg && !item_ready |=> hold_valid_reg && $stable(hold_reg))
        else $error("held byte lost before hand-off");

    // The row's last byte restarts the column count
    a_col_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && last_byte |=> byte_in_row_reg == '0)
        else $error("byte counter did not wrap at row end");

endmodule

>>> hdl/mbre_pixel_serializer.sv
// Output stage: shifts a held byte out, one RGB565 pixel per unstalled cycle.
// Depends on mbre_pkg.
module mbre_pixel_serializer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  mbre_pkg::mbre_cfg_t            cfg,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  mbre_pkg::mbre_item_t           item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [mbre_pkg::COLOR_W-1:0]   m_pixel_color,
    output logic                           m_run_last,
    output logic                           m_row_end,
    output logic                           m_image_end
);
    import mbre_pkg::*;

    // Shift state for the byte being expanded
    logic                 busy_reg, busy_next;
    logic [BYTE_W-1:0]    data_reg, data_next;
    logic [PIX_IDX_W-1:0] left_reg, left_next;
    logic                 last_byte_reg, last_byte_next;
    logic                 last_row_reg, last_row_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0]   color_reg, color_next;
    logic                 run_last_reg, run_last_next;
    logic                 row_end_reg, row_end_next;
    logic                 image_end_reg, image_end_next;

    logic advance;
    logic final_pix;
    logic take;

    assign advance    = !out_valid_reg || m_ready;
    assign final_pix  = (left_reg == '0);
    assign item_ready = !busy_reg || (advance && final_pix);
    assign take       = item_valid && item_ready;

    always_comb begin
        busy_next      = busy_reg;
        data_next      = data_reg;
        left_next      = left_reg;
        last_byte_next = last_byte_reg;
        last_row_next  = last_row_reg;
        out_valid_next = out_valid_reg;
        color_next     = color_reg;
        run_last_next  = run_last_reg;
        row_end_next   = row_end_reg;
        image_end_next = image_end_reg;

        // Emit the next pixel when the output register frees up
        if (advance) begin
            out_valid_next = busy_reg;
            if (busy_reg) begin
                color_next     = data_reg[BYTE_W-1] ? cfg.palette[cfg.fg_index]
                                                    : cfg.palette[cfg.bg_index];
                run_last_next  = final_pix;
                row_end_next   = final_pix && last_byte_reg;
                image_end_next = final_pix && last_byte_reg && last_row_reg;
                data_next      = data_reg << 1;
                left_next      = left_reg - PIX_IDX_W'(1);
                if (final_pix) begin
                    busy_next = 1'b0;
                end
            end
        end

        // Load the next byte, back to back with the previous one's last pixel
        if (take) begin
            busy_next      = 1'b1;
            data_next      = item.data;
            left_next      = item.last_idx;
            last_byte_next = item.last_byte;
            last_row_next  = item.last_row;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg      <= data_next;
        left_reg      <= left_next;
        last_byte_reg <= last_byte_next;
        last_row_reg  <= last_row_next;
        color_reg     <= color_next;
        run_last_reg  <= run_last_next;
        row_end_reg   <= row_end_next;
        image_end_reg <= image_end_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_pixel_color = color_reg;
    assign m_run_last    = run_last_reg;
    assign m_row_end     = row_end_reg;
    assign m_image_end   = image_end_reg;

    // Flag nesting: image end is a row end, row end closes a byte
    a_image_in_row: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && image_end_reg |-> row_end_reg)
        else $error("image end without row end");

    a_row_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && row_end_reg |-> run_last_reg)
        else $error("row end not on last pixel of byte");

    // A byte is loaded only when the previous one is done or finishing
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !(advance && final_pix) |=> busy_reg && (left_reg == $past(left_reg)
            || left_reg == $past(left_reg) - PIX_IDX_W'(1)))
        else $error("byte replaced while still expanding");

endmodule

>>> hdl/mono_bitmap_to_rgb565_expander_unit.sv
// Top level of the monochrome bitmap to RGB565 expander.
// Depends on mbre_pkg, mbre_cfg_regs, mbre_byte_front, mbre_pixel_serializer.
//
// Each accepted bitmap byte (MSB = leftmost pixel) yields one 16-bit pixel per
// cycle on the m_ channel while m_ready lets it through: eight pixels, or
// (pixels_per_row-1)%8+1 for the last byte of a row, colored from the palette
// entry chosen by fg_index or bg_index. The pixel serializer sets the rate: a
// byte occupies the output until all of its pixels are out. A one-byte holding
// register lets the next byte be accepted while the current one is expanding;
// a byte passes the holding, serializer shift and output registers before its
// first pixel shows. run_last, row_end and image_end mark the last pixel of a
// byte, row and image; the byte and row counters wrap so the next image
// follows directly. Registers are to be written over APB (4-byte spacing) only
// while the block is idle; the block does not enforce it. pready is tied high.
module mono_bitmap_to_rgb565_expander_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mbre_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mbre_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mbre_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // Bitmap byte input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mbre_pkg::BYTE_W-1:0]       s_bitmap_byte,
    // Pixel output
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mbre_pkg::COLOR_W-1:0]      m_pixel_color,
    output logic                              m_run_last,
    output logic                              m_row_end,
    output logic                              m_image_end
);
    import mbre_pkg::*;

    mbre_cfg_t  cfg;
    mbre_item_t item;
    logic       item_valid;
    logic       item_ready;

    mbre_cfg_regs u_cfg_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mbre_byte_front u_byte_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_bitmap_byte (s_bitmap_byte),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item)
    );

    mbre_pixel_serializer u_pixel_serializer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .item          (item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_color (m_pixel_color),
        .m_run_last    (m_run_last),
        .m_row_end     (m_row_end),
        .m_image_end   (m_image_end)
    );

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for mono_bitmap_to_rgb565_expander_unit.
// Depends on mbre_pkg and the block RTL; sets registers over APB, streams bitmap
// bytes and checks every pixel against an in-bench expansion model or typed table rows.
module tb_top;
    import mbre_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_BYTES  = 260;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 20_000;
    localparam int TAIL_CYCLES   = 20;

    typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

    // One line of the directed table; typed rows carry their expected pixels
    typedef struct packed {
        row_kind_t         kind;
        mbre_reg_t         addr_reg;
        logic [31:0]       data;
        logic              typed;
        logic [3:0]        n_pix;
        logic [COLOR_W-1:0] color;
        logic              row_end;
        logic              image_end;
    } dir_row_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               run_last;
        logic               row_end;
        logic               image_end;
    } pixel_exp_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_bitmap_byte;
    logic                  m_valid;
    logic                  m_ready;
    logic [COLOR_W-1:0]    m_pixel_color;
    logic                  m_run_last;
    logic                  m_row_end;
    logic                  m_image_end;

    mono_bitmap_to_rgb565_expander_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_bitmap_byte (s_bitmap_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_color (m_pixel_color),
        .m_run_last    (m_run_last),
        .m_row_end     (m_row_end),
        .m_image_end   (m_image_end)
    );

    // Register mirror and position counters of the expansion model
    logic [COLOR_W-1:0]    pal_m [PAL_ENTRIES];
    logic [PAL_IDX_W-1:0]  fg_m;
    logic [PAL_IDX_W-1:0]  bg_m;
    logic [SIZE_W-1:0]     width_m;
    logic [SIZE_W-1:0]     height_m;
    logic [BYTE_CNT_W-1:0] byte_pos;
    logic [ROW_CNT_W-1:0]  row_pos;

    pixel_exp_t pixels_due[$];
    dir_row_t   dir_tab[$];
    int         err_count;
    int         bytes_sent;
    int         pixels_checked;
    int         cfg_writes;
    int         cycle_count;
    bit         calm;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // Mostly short gaps, a few long ones, none while calm
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Out-of-range sizes are pinned to 1 .. max
    function automatic int fit_size(input logic [SIZE_W-1:0] v, input int max_v);
        if (v == '0) return 1;
        if (int'(v) > max_v) return max_v;
        return int'(v);
    endfunction

    // Expands one accepted byte into its pixels and advances the counters
    function automatic void expand_byte(input logic [BYTE_W-1:0] b, input bit keep);
        int         width;
        int         height;
        int         per_row;
        int         n_pix;
        bit         last_byte;
        bit         last_row;
        pixel_exp_t px;
        width     = fit_size(width_m, MAX_WIDTH);
        height    = fit_size(height_m, MAX_HEIGHT);
        per_row   = (width + 7) / 8;
        last_byte = (int'(byte_pos) + 1) >= per_row;
        last_row  = (int'(row_pos) + 1) >= height;
        n_pix     = last_byte ? ((width - 1) % 8) + 1 : 8;
        for (int k = 0; k < n_pix; k++) begin
            px.color     = pal_m[b[7-k] ? fg_m : bg_m];
            px.run_last  = (k == n_pix - 1);
            px.row_end   = px.run_last && last_byte;
            px.image_end = px.row_end && last_row;
            if (keep) pixels_due.push_back(px);
        end
        if (last_byte) begin
            byte_pos = '0;
            row_pos  = last_row ? '0 : row_pos + 1'b1;
        end else begin
            byte_pos = byte_pos + 1'b1;
        end
    endfunction

    // APB write: setup cycle, access cycle, then release
    task automatic cfg_write(input mbre_reg_t r, input logic [31:0] v);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (r)
            REG_FG_INDEX:   fg_m = v[PAL_IDX_W-1:0];
            REG_BG_INDEX:   bg_m = v[PAL_IDX_W-1:0];
            REG_ROW_PIXELS: width_m = v[SIZE_W-1:0];
            REG_IMG_ROWS:   height_m = v[SIZE_W-1:0];
            default:        pal_m[int'(r)] = v[COLOR_W-1:0];
        endcase
        cfg_writes++;
    endtask

    // Block goes idle: input dropped, all pixels out, then a settling margin
    task automatic settle();
        s_valid <= 1'b0;
        while (pixels_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Returns in the time step of the accepting edge
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_bitmap_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    function automatic logic [31:0] pick_size(input int typical);
        case ($urandom_range(0, 19))
            0:       return 32'd0;
            1:       return 32'd512;
            2:       return 32'd1023;
            3:       return $urandom_range(513, 1023);
            default: return $urandom_range(1, typical);
        endcase
    endfunction

    function automatic logic [31:0] pick_color();
        case ($urandom_range(0, 9))
            0:       return 32'h0000;
            1:       return 32'hFFFF;
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // Rewrites a random subset of registers, sometimes with junk above the field
    task automatic random_setup();
        logic [31:0] v;
        int          fld_w;
        for (int i = 0; i < 8; i++) begin
            if ($urandom_range(0, 1) == 0) continue;
            case (mbre_reg_t'(i))
                REG_FG_INDEX, REG_BG_INDEX: begin
                    v     = $urandom_range(0, 3);
                    fld_w = PAL_IDX_W;
                end
                REG_ROW_PIXELS: begin
                    v     = pick_size(40);
                    fld_w = SIZE_W;
                end
                REG_IMG_ROWS: begin
                    v     = pick_size(6);
                    fld_w = SIZE_W;
                end
                default: begin
                    v     = pick_color();
                    fld_w = COLOR_W;
                end
            endcase
            if ($urandom_range(0, 3) == 0) v = v | ($urandom() << fld_w);
            cfg_write(mbre_reg_t'(i), v);
        end
    endtask

    // Result side: random back-pressure
    initial begin
        int hi;
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            hi = $urandom_range(1, 24);
            m_ready <= 1'b1;
            repeat (hi) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // Pixel transaction checker
    always @(posedge aclk) begin
        pixel_exp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pixels_due.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel color %h", m_pixel_color));
            end else begin
                want = pixels_due.pop_front();
                if (m_pixel_color !== want.color)
                    report_mismatch($sformatf("pixel %0d color %h, expected %h",
                                              pixels_checked, m_pixel_color, want.color));
                if (m_run_last !== want.run_last)
                    report_mismatch($sformatf("pixel %0d run_last %b, expected %b",
                                              pixels_checked, m_run_last, want.run_last));
                if (m_row_end !== want.row_end)
                    report_mismatch($sformatf("pixel %0d row_end %b, expected %b",
                                              pixels_checked, m_row_end, want.row_end));
                if (m_image_end !== want.image_end)
                    report_mismatch($sformatf("pixel %0d image_end %b, expected %b",
                                              pixels_checked, m_image_end, want.image_end));
                pixels_checked++;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles", cycle_count);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [BYTE_W-1:0] b;
        int                n;
        int                rand_sent;
        pixel_exp_t        px;

        aresetn       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_valid       <= 1'b0;
        s_bitmap_byte <= '0;
        err_count     = 0;
        bytes_sent    = 0;
        pixels_checked = 0;
        cfg_writes    = 0;
        rand_sent     = 0;
        calm          = 1'b0;

        // Mirror starts at the reset values
        foreach (pal_m[i]) pal_m[i] = '0;
        fg_m     = 2'd1;
        bg_m     = 2'd0;
        width_m  = 10'd8;
        height_m = 10'd8;
        byte_pos = '0;
        row_pos  = '0;

        // After reset: palette all zero, one byte per row of eight rows
        dir_tab.push_back('{ROW_BYTE, REG_PALETTE_0, 32'hFF, 1'b1, 4'd8, 16'h0000, 1'b1, 1'b0});
        dir_tab.push_back('{ROW_CFG, REG_PALETTE_0, 32'h0000, 1'b0, 4'd0, 16'h0, 1'b0, 1'b0});
        dir_tab.push_back('{ROW_CFG, REG_PALETTE_1, 32'hFFFF, 1'b0, 4'd0, 16'h0, 1'b0, 1'b0});
        dir_tab.push_back('{ROW_CFG, REG_PALETTE_2, 32'hA5A5, 1'b0, 4'd0, 16'h0, 1'b0, 1'b0});
        dir_tab.push_back('{ROW_CFG, REG_PALETTE_3, 32'h5A5A, 1'b0, 4'd0, 16'h0, 1'b0, 1'b0});
        dir_tab.push_back('{ROW_CFG, REG_FG_INDEX, 32'd3, 1'b0, 4'd0, 16'h0, 1'b0, 1'b0});
        dir_tab.push_back('{ROW_CFG, REG_BG_INDEX, 32'd2, 1'b0, 4'd0, 16'h0, 1'b0, 1'b0});
        dir_tab.push_back('{ROW_CFG, REG_ROW_PIXELS, 32'd12, 1'b0, 4'd0, 16'h0, 1'b0, 1'b0});
        dir_tab.push_back('{ROW_CFG, REG_IMG_ROWS, 32'd2, 1'b0, 4'd0, 16'h0, 1'b0, 1'b0});
        // Two-byte rows, short last byte; this row is the last of the image
        dir_tab.push_back('{ROW_BYTE, REG_PALETTE_0, 32'hFF, 1'b1, 4'd8, 16'h5A5A, 1'b0, 1'b0});
        dir_tab.push_back('{ROW_BYTE, REG_PALETTE_0, 32'h00, 1'b1, 4'd4, 16'hA5A5, 1'b1, 1'b1});
        dir_tab.push_back('{ROW_BYTE, REG_PALETTE_0, 32'h81, 1'b0, 4'd0, 16'h0, 1'b0, 1'b0});
        dir_tab.push_back('{ROW_BYTE, REG_PALETTE_0, 32'h3C, 1'b0, 4'd0, 16'h0, 1'b0, 1'b0});
        // Zero width acts as one pixel
        dir_tab.push_back('{ROW_CFG, REG_ROW_PIXELS, 32'd0, 1'b0, 4'd0, 16'h0, 1'b0, 1'b0});
        dir_tab.push_back('{ROW_BYTE, REG_PALETTE_0, 32'h80, 1'b1, 4'd1, 16'h5A5A, 1'b1, 1'b1});
        dir_tab.push_back('{ROW_BYTE, REG_PALETTE_0, 32'h7F, 1'b1, 4'd1, 16'hA5A5, 1'b1, 1'b0});
        // Zero height acts as one row
        dir_tab.push_back('{ROW_CFG, REG_IMG_ROWS, 32'd0, 1'b0, 4'd0, 16'h0, 1'b0, 1'b0});
        dir_tab.push_back('{ROW_BYTE, REG_PALETTE_0, 32'h55, 1'b1, 4'd1, 16'hA5A5, 1'b1, 1'b1});
        // Oversized width, then shrink so the byte counter sits past the row end
        dir_tab.push_back('{ROW_CFG, REG_ROW_PIXELS, 32'd1023, 1'b0, 4'd0, 16'h0, 1'b0, 1'b0});
        dir_tab.push_back('{ROW_BYTE, REG_PALETTE_0, 32'hAA, 1'b0, 4'd0, 16'h0, 1'b0, 1'b0});
        dir_tab.push_back('{ROW_BYTE, REG_PALETTE_0, 32'h0F, 1'b0, 4'd0, 16'h0, 1'b0, 1'b0});
        dir_tab.push_back('{ROW_BYTE, REG_PALETTE_0, 32'hF0, 1'b0, 4'd0, 16'h0, 1'b0, 1'b0});
        dir_tab.push_back('{ROW_CFG, REG_ROW_PIXELS, 32'd9, 1'b0, 4'd0, 16'h0, 1'b0, 1'b0});
        dir_tab.push_back('{ROW_BYTE, REG_PALETTE_0, 32'h00, 1'b1, 4'd1, 16'hA5A5, 1'b1, 1'b1});
        // Palette extremes, oversized height, then shrink past the current row
        dir_tab.push_back('{ROW_CFG, REG_ROW_PIXELS, 32'd8, 1'b0, 4'd0, 16'h0, 1'b0, 1'b0});
        dir_tab.push_back('{ROW_CFG, REG_IMG_ROWS, 32'd1023, 1'b0, 4'd0, 16'h0, 1'b0, 1'b0});
        dir_tab.push_back('{ROW_CFG, REG_FG_INDEX, 32'd1, 1'b0, 4'd0, 16'h0, 1'b0, 1'b0});
        dir_tab.push_back('{ROW_CFG, REG_BG_INDEX, 32'd0, 1'b0, 4'd0, 16'h0, 1'b0, 1'b0});
        dir_tab.push_back('{ROW_BYTE, REG_PALETTE_0, 32'hFF, 1'b1, 4'd8, 16'hFFFF, 1'b1, 1'b0});
        dir_tab.push_back('{ROW_BYTE, REG_PALETTE_0, 32'h00, 1'b1, 4'd8, 16'h0000, 1'b1, 1'b0});
        dir_tab.push_back('{ROW_BYTE, REG_PALETTE_0, 32'hC3, 1'b0, 4'd0, 16'h0, 1'b0, 1'b0});
        dir_tab.push_back('{ROW_CFG, REG_IMG_ROWS, 32'd2, 1'b0, 4'd0, 16'h0, 1'b0, 1'b0});
        dir_tab.push_back('{ROW_BYTE, REG_PALETTE_0, 32'h00, 1'b1, 4'd8, 16'h0000, 1'b1, 1'b1});

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                settle();
                cfg_write(dir_tab[i].addr_reg, dir_tab[i].data);
            end else begin
                send_byte(dir_tab[i].data[BYTE_W-1:0]);
                expand_byte(dir_tab[i].data[BYTE_W-1:0], !dir_tab[i].typed);
                if (dir_tab[i].typed) begin
                    for (int k = 0; k < int'(dir_tab[i].n_pix); k++) begin
                        px.color     = dir_tab[i].color;
                        px.run_last  = (k == int'(dir_tab[i].n_pix) - 1);
                        px.row_end   = px.run_last && dir_tab[i].row_end;
                        px.image_end = px.run_last && dir_tab[i].image_end;
                        pixels_due.push_back(px);
                    end
                end
            end
        end

        // Random phases: new settings, then a burst of bytes; some bursts run without idling
        while (rand_sent < RANDOM_BYTES) begin
            settle();
            random_setup();
            calm = ($urandom_range(0, 4) == 0);
            n = $urandom_range(6, 36);
            for (int j = 0; j < n && rand_sent < RANDOM_BYTES; j++) begin
                b = $urandom_range(0, 255);
                send_byte(b);
                expand_byte(b, 1'b1);
                rand_sent++;
            end
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        // Drain and check for leftovers
        for (int w = 0; w < DRAIN_LIMIT && pixels_due.size() != 0; w++) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (pixels_due.size() != 0)
            report_mismatch($sformatf("%0d expected pixels never came out", pixels_due.size()));

        $display("run covered %0d bitmap bytes and %0d checked pixels over %0d register writes",
                 bytes_sent, pixels_checked, cfg_writes);
        $display("mismatches: %0d", err_count);
        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
